// File: design/hamming_fft_magnitude_spectrogram_unit_defines.svh
// Assertion macros of the spectrogram RTL, used by the frame engine.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef HAMMING_FFT_MAGNITUDE_SPECTROGRAM_UNIT_DEFINES_SVH
`define HAMMING_FFT_MAGNITUDE_SPECTROGRAM_UNIT_DEFINES_SVH

// same-cycle implication
`define HFMS_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define HFMS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/hfms_pkg.sv
// Shared types, constants and table functions of the spectrogram unit.
// No dependencies; used by all modules of the block.
`default_nettype none
package hfms_pkg;

   localparam int FFT_POINTS_DEF = 64;
   localparam int DATA_W = 40;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int HOP_W = 7;
   localparam int MAG_W = 28;
   localparam int SQ_W = 58;
   localparam logic [HOP_W-1:0] HOP_MAX = 7'd64;
   localparam logic signed [16:0] INV_SQRT_TAU = 17'sd26145;

   typedef struct packed {
      logic [15:0] sample;
      logic        start;
      logic        emit;
   } hfms_item_type;

   function automatic int fft_lg(input int pts);
      int lg;
      lg = 3;
      if (pts >= 16) lg = 4;
      if (pts >= 32) lg = 5;
      if (pts >= 64) lg = 6;
      return lg;
   endfunction

   function automatic int cos_q(input int k);
      int v;
      case (k)
         0: v = 32768;
         1: v = 32610;
         2: v = 32138;
         3: v = 31357;
         4: v = 30274;
         5: v = 28899;
         6: v = 27246;
         7: v = 25330;
         8: v = 23170;
         9: v = 20788;
         10: v = 18205;
         11: v = 15447;
         12: v = 12540;
         13: v = 9512;
         14: v = 6393;
         15: v = 3212;
         default: v = 0;
      endcase
      return v;
   endfunction

   function automatic logic signed [16:0] cos64(input logic [5:0] k);
      int ki;
      int v;
      ki = int'(k);
      if (ki <= 16) v = cos_q(ki);
      else if (ki <= 32) v = -cos_q(32 - ki);
      else if (ki <= 48) v = -cos_q(ki - 32);
      else v = cos_q(64 - ki);
      return 17'(v);
   endfunction

   function automatic logic signed [16:0] sin64(input logic [5:0] k);
      return cos64(6'(k + 6'd48));
   endfunction

   function automatic logic [15:0] ham_weight(input logic [5:0] k);
      int c;
      int t;
      c = int'(cos64(k));
      t = (15127 * (c + 32768) + 16384) >>> 15;
      return 16'(32768 - t);
   endfunction

endpackage
`default_nettype wire

// File: design/hfms_front.sv
// Front end: takes samples, tracks fill count and hop phase, tags signal starts and frame emits.
// Depends on hfms_pkg.
`default_nettype none
module hfms_front #(
   parameter int FFT_POINTS = hfms_pkg::FFT_POINTS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [15:0]                 req_tdata,
   input  wire logic                        req_tuser,
   input  wire logic                        csr_wr_en,
   input  wire logic [hfms_pkg::HOP_W-1:0]  csr_wr_data,
   input  wire logic                        q_full,
   output logic                             q_push,
   output hfms_pkg::hfms_item_type          q_item
);
   localparam int LG = hfms_pkg::fft_lg(FFT_POINTS);
   localparam int NPT = 1 << LG;
   localparam logic [LG:0] FILL_FULL = (LG+1)'(NPT);

   logic [hfms_pkg::HOP_W-1:0] hop_ff;
   logic [LG:0] fill_ff, fill_in, fill_cur;
   logic [5:0] phase_ff, phase_in, phase_cur;
   logic [hfms_pkg::HOP_W-1:0] hop_eff, phase_next;
   logic emit;

   assign req_tready = !q_full;
   assign q_push = req_tvalid && !q_full;

   always_comb begin
      hop_eff = hop_ff;
      if (hop_ff == '0) hop_eff = 7'd1;
      else if (hop_ff > hfms_pkg::HOP_MAX) hop_eff = hfms_pkg::HOP_MAX;
      fill_cur = req_tuser ? '0 : fill_ff;
      phase_cur = req_tuser ? '0 : phase_ff;
      phase_next = {1'b0, phase_cur} + 7'd1;
      emit = 1'b0;
      fill_in = fill_cur;
      phase_in = phase_cur;
      if (fill_cur < FILL_FULL) begin
         fill_in = fill_cur + 1'b1;
         if (fill_in == FILL_FULL) begin
            emit = 1'b1;
            phase_in = '0;
         end
      end else if (phase_next >= hop_eff) begin
         emit = 1'b1;
         phase_in = '0;
      end else begin
         phase_in = phase_next[5:0];
      end
      q_item.sample = req_tdata;
      q_item.start = req_tuser;
      q_item.emit = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff <= 7'd32;
         fill_ff <= '0;
         phase_ff <= '0;
      end else begin
         if (csr_wr_en) hop_ff <= csr_wr_data;
         if (q_push) begin
            fill_ff <= fill_in;
            phase_ff <= phase_in;
         end
      end
   end
endmodule
`default_nettype wire

// File: design/hfms_queue.sv
// Short queue of tagged samples between front end and frame engine.
// Depends on hfms_pkg.
`default_nettype none
module hfms_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire hfms_pkg::hfms_item_type push_item,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         pop_valid,
   output hfms_pkg::hfms_item_type      pop_item
);
   hfms_pkg::hfms_item_type slot_ff [hfms_pkg::QUEUE_DEPTH];
   logic [hfms_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [hfms_pkg::QPTR_W:0] cnt_ff;

   assign full = cnt_ff == (hfms_pkg::QPTR_W+1)'(hfms_pkg::QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_item = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

// File: design/hfms_back.sv
// Frame engine: sample window, windowed leaf load, radix-2 FFT, magnitudes.
// Depends on hfms_pkg and the assertion macro header.
`include "hamming_fft_magnitude_spectrogram_unit_defines.svh"
`default_nettype none
module hfms_back #(
   parameter int FFT_POINTS = hfms_pkg::FFT_POINTS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   input  wire hfms_pkg::hfms_item_type pop_item,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [63:0]                  rsp_tdata,
   output logic                         rsp_tlast
);
   localparam int LG = hfms_pkg::fft_lg(FFT_POINTS);
   localparam int NPT = 1 << LG;
   localparam int DW = hfms_pkg::DATA_W;
   localparam int SW = hfms_pkg::SQ_W;
   localparam logic [LG-1:0] IDX_LAST = LG'(NPT - 1);
   localparam logic [LG-2:0] BF_LAST = (LG-1)'(NPT/2 - 1);
   localparam logic [2:0] STAGE_LAST = 3'(LG);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LD_RD   = 4'd1;
   localparam logic [3:0] S_LD_MUL  = 4'd2;
   localparam logic [3:0] S_LD_LEAF = 4'd3;
   localparam logic [3:0] S_LD_WR   = 4'd4;
   localparam logic [3:0] S_BF_RD   = 4'd5;
   localparam logic [3:0] S_BF_MUL  = 4'd6;
   localparam logic [3:0] S_BF_WA   = 4'd7;
   localparam logic [3:0] S_BF_WB   = 4'd8;
   localparam logic [3:0] S_MG_RD   = 4'd9;
   localparam logic [3:0] S_MG_SQ   = 4'd10;
   localparam logic [3:0] S_MG_SUM  = 4'd11;
   localparam logic [3:0] S_MG_ROOT = 4'd12;
   localparam logic [3:0] S_MG_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;

   logic [15:0] win_mem [NPT];
   logic [15:0] win_q_ff;
   logic [LG-1:0] wptr_ff, win_addr;

   logic signed [DW-1:0] re_mem [NPT];
   logic signed [DW-1:0] im_mem [NPT];
   logic signed [DW-1:0] ra_ff, ia_ff, rb_ff, ib_ff;
   logic [LG-1:0] addr_a, addr_b, waddr;
   logic we;
   logic signed [DW-1:0] wre, wim;

   logic [LG-1:0] idx_ff, idx_in;
   logic [2:0] stage_ff, stage_in;
   logic [LG-2:0] bf_ff, bf_in;

   logic signed [32:0] x_ff;
   logic signed [49:0] leaf_ff;
   logic signed [56:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [DW-1:0] dr_ff, di_ff, dr_in, di_in;

   logic signed [63:0] sqr_ff, sqi_ff;
   logic [SW-1:0] sq_ff, sq_in, rx_ff, rx_in, rr_ff, rr_in, bit_ff, bit_in;
   logic [hfms_pkg::MAG_W-1:0] peak_ff, peak_in, mag;
   logic load;

   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic rsp_last_ff;

   logic [LG-1:0] jx, lo_mask, half_bit, bf_a, bf_b, rev;
   logic [5:0] tw;
   logic signed [16:0] tw_c, tw_s;
   logic signed [33:0] leaf_rnd;
   logic signed [57:0] tr_sum, ti_sum;
   logic signed [DW-1:0] tr, ti;
   logic signed [DW:0] r8_full, i8_full;
   logic signed [31:0] r8, i8;
   logic [SW-1:0] try_sum;
   logic [29:0] m_round;

   // butterfly addressing, twiddles and bit-reversed index
   always_comb begin
      jx = LG'(bf_ff);
      half_bit = LG'(1) << (stage_ff - 3'd1);
      lo_mask = half_bit - 1'b1;
      bf_a = ((jx & ~lo_mask) << 1) | (jx & lo_mask);
      bf_b = bf_a | half_bit;
      tw = 6'(6'(jx & lo_mask) << (3'd6 - stage_ff));
      tw_c = hfms_pkg::cos64(tw);
      tw_s = hfms_pkg::sin64(tw);
      for (int k = 0; k < LG; k++) rev[k] = idx_ff[LG-1-k];
   end

   assign win_addr = wptr_ff + idx_ff;
   assign addr_a = (state_ff >= S_MG_RD) ? idx_ff : bf_a;
   assign addr_b = bf_b;

   always_ff @(posedge clock) begin
      if (pop && pop_valid) win_mem[wptr_ff] <= pop_item.sample;
      win_q_ff <= win_mem[win_addr];
   end

   always_ff @(posedge clock) begin
      if (we) begin
         re_mem[waddr] <= wre;
         im_mem[waddr] <= wim;
      end
      ra_ff <= re_mem[addr_a];
      ia_ff <= im_mem[addr_a];
      rb_ff <= re_mem[addr_b];
      ib_ff <= im_mem[addr_b];
   end

   always_comb begin
      leaf_rnd = 34'((leaf_ff + 50'sd32768) >>> 16);
      tr_sum = (58'(p1_ff) + 58'(p2_ff) + 58'sd16384) >>> 15;
      ti_sum = (58'(p3_ff) - 58'(p4_ff) + 58'sd16384) >>> 15;
      tr = tr_sum[DW-1:0];
      ti = ti_sum[DW-1:0];
      r8_full = ((DW+1)'(ra_ff) + (DW+1)'(64)) >>> 7;
      i8_full = ((DW+1)'(ia_ff) + (DW+1)'(64)) >>> 7;
      r8 = r8_full[31:0];
      i8 = i8_full[31:0];
      try_sum = rr_ff + bit_ff;
      m_round = rr_ff[29:0] + ((rx_ff > rr_ff) ? 30'd1 : 30'd0);
      mag = (m_round > 30'(2**hfms_pkg::MAG_W - 1)) ? '1 : m_round[hfms_pkg::MAG_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      stage_in = stage_ff;
      bf_in = bf_ff;
      pop = 1'b0;
      we = 1'b0;
      waddr = bf_a;
      wre = '0;
      wim = '0;
      dr_in = dr_ff;
      di_in = di_ff;
      sq_in = sq_ff;
      rx_in = rx_ff;
      rr_in = rr_ff;
      bit_in = bit_ff;
      peak_in = peak_ff;
      load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop = 1'b1;
               if (pop_item.start) peak_in = '0;
               idx_in = '0;
               if (pop_item.emit) state_in = S_LD_RD;
            end
         end
         S_LD_RD: state_in = S_LD_MUL;
         S_LD_MUL: state_in = S_LD_LEAF;
         S_LD_LEAF: state_in = S_LD_WR;
         S_LD_WR: begin
            we = 1'b1;
            waddr = rev;
            wre = DW'(leaf_rnd);
            wim = '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               stage_in = 3'd1;
               bf_in = '0;
               state_in = S_BF_RD;
            end else begin
               state_in = S_LD_RD;
            end
         end
         S_BF_RD: state_in = S_BF_MUL;
         S_BF_MUL: state_in = S_BF_WA;
         S_BF_WA: begin
            we = 1'b1;
            waddr = bf_a;
            wre = ra_ff + tr;
            wim = ia_ff + ti;
            dr_in = ra_ff - tr;
            di_in = ia_ff - ti;
            state_in = S_BF_WB;
         end
         S_BF_WB: begin
            we = 1'b1;
            waddr = bf_b;
            wre = dr_ff;
            wim = di_ff;
            bf_in = bf_ff + 1'b1;
            state_in = S_BF_RD;
            if (bf_ff == BF_LAST) begin
               stage_in = stage_ff + 3'd1;
               if (stage_ff == STAGE_LAST) begin
                  idx_in = '0;
                  state_in = S_MG_RD;
               end
            end
         end
         S_MG_RD: state_in = S_MG_SQ;
         S_MG_SQ: state_in = S_MG_SUM;
         S_MG_SUM: begin
            sq_in = SW'(sqr_ff) + SW'(sqi_ff);
            state_in = S_MG_ROOT;
            rx_in = SW'(sqr_ff) + SW'(sqi_ff);
            rr_in = '0;
            bit_in = SW'(1) << (SW - 2);
         end
         S_MG_ROOT: begin
            if (bit_ff == '0) begin
               state_in = S_MG_OUT;
            end else begin
               if (rx_ff >= try_sum) begin
                  rx_in = rx_ff - try_sum;
                  rr_in = (rr_ff >> 1) + bit_ff;
               end else begin
                  rr_in = rr_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_MG_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load = 1'b1;
               if (mag > peak_ff) peak_in = mag;
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff == IDX_LAST) ? S_IDLE : S_MG_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= $signed(win_q_ff) * $signed({1'b0, hfms_pkg::ham_weight(6'(idx_ff) << (6 - LG))});
      leaf_ff <= x_ff * hfms_pkg::INV_SQRT_TAU;
      p1_ff <= rb_ff * tw_c;
      p2_ff <= ib_ff * tw_s;
      p3_ff <= ib_ff * tw_c;
      p4_ff <= rb_ff * tw_s;
      sqr_ff <= r8 * r8;
      sqi_ff <= i8 * i8;
      dr_ff <= dr_in;
      di_ff <= di_in;
      sq_ff <= sq_in;
      rx_ff <= rx_in;
      rr_ff <= rr_in;
      bit_ff <= bit_in;
      if (load) begin
         rsp_data_ff <= {2'b00, peak_in, mag, 6'(idx_ff)};
         rsp_last_ff <= idx_ff == IDX_LAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wptr_ff <= '0;
         idx_ff <= '0;
         stage_ff <= 3'd1;
         bf_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop) wptr_ff <= wptr_ff + 1'b1;
         idx_ff <= idx_in;
         stage_ff <= stage_in;
         bf_ff <= bf_in;
         peak_ff <= peak_in;
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   `HFMS_ASSERT_NOW(a_pop_idle, clock, reset, pop, state_ff == S_IDLE && pop_valid, "pop outside idle")
   `HFMS_ASSERT_NOW(a_load_free, clock, reset, load, !rsp_valid_ff || rsp_tready, "result overwritten")
   `HFMS_ASSERT_NEXT(a_root_done, clock, reset, state_ff == S_MG_ROOT && bit_ff == '0, state_ff == S_MG_OUT, "root did not finish")
endmodule
`default_nettype wire

// File: design/hamming_fft_magnitude_spectrogram_unit.sv
// Top level of the Hamming-windowed FFT magnitude spectrogram unit.
// Depends on hfms_pkg, hfms_front, hfms_queue, hfms_back.
//
//   channel  dir  payload
//   req_     in   tdata[15:0] sample, tuser start_of_signal
//   rsp_     out  tdata[5:0] bin_index, [33:6] magnitude, [61:34] peak_so_far; tlast frame_last
//   csr_     in   wr_data[6:0] hop_size
//
// Samples are popped from the queue while the engine is idle; up to four samples buffer
// while a frame runs. A frame of N bins runs as a windowed load of N points, then the
// radix-2 butterflies, then per bin the magnitude with a serial square root.
// Reset: synchronous, active high; hop_size returns to 32. Stalls on rsp_ hold the engine.
`default_nettype none
module hamming_fft_magnitude_spectrogram_unit #(
   parameter int FFT_POINTS = hfms_pkg::FFT_POINTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,   // sample
   input  wire logic                       req_tuser,   // start_of_signal
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [63:0]                     rsp_tdata,   // bin_index, magnitude, peak_so_far
   output logic                            rsp_tlast,   // frame_last
   input  wire logic                       csr_wr_en,
   input  wire logic [hfms_pkg::HOP_W-1:0] csr_wr_data
);
   logic q_full, q_push, q_pop, q_valid;
   hfms_pkg::hfms_item_type q_in, q_out;

   hfms_front #(.FFT_POINTS(FFT_POINTS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .q_full(q_full), .q_push(q_push), .q_item(q_in)
   );

   hfms_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_item(q_in), .full(q_full),
      .pop(q_pop), .pop_valid(q_valid), .pop_item(q_out)
   );

   hfms_back #(.FFT_POINTS(FFT_POINTS)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(q_valid), .pop_item(q_out), .pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule
`default_nettype wire
